FILE: rtl/tct_pkg.sv
package tct_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned SlotW = $clog2(TableSize);
  localparam int unsigned SlotCntW = SlotW + 1;
  localparam logic [31:0] FnvBasis = 32'h811C9DC5;
  localparam logic [31:0] FnvPrime = 32'h01000193;

  localparam logic [2:0] OutNotTcp = 3'd0;
  localparam logic [2:0] OutMatchActive = 3'd1;
  localparam logic [2:0] OutCreated = 3'd2;
  localparam logic [2:0] OutMatchClosed = 3'd3;
  localparam logic [2:0] OutFull = 3'd4;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirFwd = 2'd1;
  localparam logic [1:0] DirRev = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        is_tcp;
    logic        fin_flag;
    logic        rst_flag;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [9:0]  slot;
    logic [1:0]  direction;
    logic        closed;
    logic [31:0] closed_out_count;
    logic [31:0] closed_in_count;
    logic [41:0] elapsed_ms;
  } res_t;

  // table entry, stored in one memory word
  typedef struct packed {
    logic        active;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] start_sec;
    logic [19:0] start_usec;
    logic [31:0] out_count;
    logic [31:0] in_count;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture packet beat
    logic hash_step;  // one FNV byte
    logic rd;         // issue table read at hash slot
    logic chk;        // evaluate read data
    logic clr_wr;     // clearing pass write
    logic fin_prep;   // compute duration parts
    logic fin_mul;    // duration multiply stage
    logic commit;     // write back and form result
    logic emit;       // drive result strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tcp;
    logic hash_last;
    logic found;
    logic probe_end;
    logic clr_last;
  } sts_t;

  // byte feed order for the hash, index 0..11
  function automatic logic [7:0] hash_byte(logic [31:0] a, logic [31:0] b,
                                           logic [15:0] c, logic [15:0] d,
                                           logic [3:0] idx);
    logic [7:0] r;
    r = '0;
    unique case (idx)
      4'd0: r = a[31:24];
      4'd1: r = a[23:16];
      4'd2: r = a[15:8];
      4'd3: r = a[7:0];
      4'd4: r = b[31:24];
      4'd5: r = b[23:16];
      4'd6: r = b[15:8];
      4'd7: r = b[7:0];
      4'd8: r = c[7:0];
      4'd9: r = c[15:8];
      4'd10: r = d[7:0];
      4'd11: r = d[15:8];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tct_ctrl.sv
module tct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tct_pkg::sts_t sts_i,
  output tct_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StHash  = 4'd2;
  localparam logic [3:0] StRead  = 4'd3;
  localparam logic [3:0] StWait  = 4'd4;
  localparam logic [3:0] StChk   = 4'd5;
  localparam logic [3:0] StPrep  = 4'd6;
  localparam logic [3:0] StMul   = 4'd7;
  localparam logic [3:0] StCommit = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy = 1'b1;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = StHash;
        end
      end
      StHash: begin
        if (!sts_i.is_tcp) begin
          state_d = StEmit;
        end else begin
          cmd_o.hash_step = 1'b1;
          if (sts_i.hash_last) state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d = StWait;
      end
      StWait: state_d = StChk;
      StChk: begin
        cmd_o.chk = 1'b1;
        if (sts_i.found || sts_i.probe_end) state_d = StPrep;
        else state_d = StWait;
      end
      StPrep: begin
        cmd_o.fin_prep = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.fin_mul = 1'b1;
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

FILE: rtl/tct_dp.sv
module tct_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tct_pkg::pkt_t pkt_i,
  input  tct_pkg::cmd_t cmd_i,
  output tct_pkg::sts_t sts_o,
  output logic          done_o,
  output tct_pkg::res_t result_o
);

  localparam int unsigned SW = tct_pkg::SlotW;
  localparam int unsigned CW = tct_pkg::SlotCntW;

  tct_pkg::entry_t mem_q [tct_pkg::TableSize];

  tct_pkg::pkt_t   pkt_q;
  tct_pkg::entry_t rd_q;
  logic [31:0]     h_q;
  logic [3:0]      hidx_q;
  logic [CW-1:0]   ptr_q;      // next slot to read
  logic [SW-1:0]   cur_q;      // slot of rd_q
  logic            found_q;
  logic [1:0]      fdir_q;
  logic            have_free_q;
  logic [SW-1:0]   free_q;
  logic [CW-1:0]   clr_q;
  logic signed [33:0] ds_q;
  logic [19:0]     dum_q;      // usec difference magnitude
  logic            du_neg_q;   // usec difference sign
  logic signed [42:0] ms_q;
  logic [10:0]     dq_q;       // usec magnitude / 1000
  tct_pkg::entry_t ent_q;      // chosen entry before this packet
  tct_pkg::res_t   res_q;
  tct_pkg::res_t   res_d;
  logic            done_q;

  // normalized tuple for hashing
  logic        lower;
  logic [31:0] na, nb;
  logic [15:0] nc, nd;
  assign lower = (pkt_q.source_address < pkt_q.dest_address) ||
                 ((pkt_q.source_address == pkt_q.dest_address) &&
                  (pkt_q.source_port < pkt_q.dest_port));
  assign na = lower ? pkt_q.source_address : pkt_q.dest_address;
  assign nb = lower ? pkt_q.dest_address : pkt_q.source_address;
  assign nc = lower ? pkt_q.source_port : pkt_q.dest_port;
  assign nd = lower ? pkt_q.dest_port : pkt_q.source_port;

  // tuple compare on read data
  logic m_fwd, m_rev;
  assign m_fwd = rd_q.src_addr == pkt_q.source_address &&
                 rd_q.dst_addr == pkt_q.dest_address &&
                 rd_q.sport == pkt_q.source_port &&
                 rd_q.dport == pkt_q.dest_port;
  assign m_rev = rd_q.src_addr == pkt_q.dest_address &&
                 rd_q.dst_addr == pkt_q.source_address &&
                 rd_q.sport == pkt_q.dest_port &&
                 rd_q.dport == pkt_q.source_port;

  assign sts_o.is_tcp = pkt_q.is_tcp;
  assign sts_o.hash_last = (hidx_q == 4'd11);
  assign sts_o.found = m_fwd || m_rev;
  assign sts_o.probe_end = (ptr_q == CW'(tct_pkg::TableSize));
  assign sts_o.clr_last = (clr_q == CW'(tct_pkg::TableSize - 1));

  // table memory: one write port, one registered read
  logic            mem_we;
  logic [SW-1:0]   mem_wa;
  tct_pkg::entry_t mem_wd;
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   k;
  logic            flg;
  logic            live;       // chosen entry is active before this packet
  assign k = found_q ? cur_q : free_q;
  assign flg = pkt_q.fin_flag || pkt_q.rst_flag;
  assign live = found_q ? ent_q.active : have_free_q;
  // first read goes to the hash slot, later ones follow the pointer
  assign rd_addr = cmd_i.rd ? h_q[SW-1:0] : ptr_q[SW-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q[SW-1:0];
    mem_wd = '0;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.commit && live) begin
      mem_we = 1'b1;
      mem_wa = k;
      mem_wd = ent_q;
      mem_wd.active = !flg;
      if (fdir_q == tct_pkg::DirFwd) mem_wd.out_count = ent_q.out_count + 32'd1;
      if (fdir_q == tct_pkg::DirRev) mem_wd.in_count = ent_q.in_count + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.rd || cmd_i.chk) rd_q <= mem_q[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + CW'(1);
      done_q <= cmd_i.emit;
    end
  end

  logic [31:0] hx;
  assign hx = h_q ^ {24'd0, tct_pkg::hash_byte(na, nb, nc, nd, hidx_q)};

  // usec magnitude / 1000 by reciprocal, exact below 2^20
  logic [40:0] du_prod;
  assign du_prod = dum_q * 21'd1073742;

  // probe datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pkt_q <= pkt_i;
      h_q <= tct_pkg::FnvBasis;
      hidx_q <= '0;
      found_q <= 1'b0;
      have_free_q <= 1'b0;
      free_q <= '0;
    end
    if (cmd_i.hash_step) begin
      h_q <= hx * tct_pkg::FnvPrime;
      hidx_q <= hidx_q + 4'd1;
    end
    if (cmd_i.rd) begin
      ptr_q <= {1'b0, h_q[SW-1:0]} + CW'(1);
      cur_q <= h_q[SW-1:0];
      found_q <= 1'b0;
    end
    if (cmd_i.chk) begin
      ent_q <= rd_q;
      if (m_fwd || m_rev) begin
        found_q <= 1'b1;
        fdir_q <= m_fwd ? tct_pkg::DirFwd : tct_pkg::DirRev;
      end else begin
        if (!rd_q.active && !have_free_q) begin
          have_free_q <= 1'b1;
          free_q <= cur_q;
        end
        ptr_q <= ptr_q + CW'(1);
        cur_q <= ptr_q[SW-1:0];
      end
    end
    if (cmd_i.fin_prep && !found_q) begin
      // new entry replaces read data
      ent_q.active <= 1'b1;
      ent_q.src_addr <= pkt_q.source_address;
      ent_q.dst_addr <= pkt_q.dest_address;
      ent_q.sport <= pkt_q.source_port;
      ent_q.dport <= pkt_q.dest_port;
      ent_q.start_sec <= pkt_q.time_sec;
      ent_q.start_usec <= pkt_q.time_usec;
      ent_q.out_count <= '0;
      ent_q.in_count <= '0;
      fdir_q <= tct_pkg::DirFwd;
      ds_q <= '0;
      dum_q <= '0;
      du_neg_q <= 1'b0;
    end else if (cmd_i.fin_prep) begin
      ds_q <= $signed({2'b0, pkt_q.time_sec}) - $signed({2'b0, ent_q.start_sec});
      if (pkt_q.time_usec >= ent_q.start_usec) begin
        dum_q <= pkt_q.time_usec - ent_q.start_usec;
        du_neg_q <= 1'b0;
      end else begin
        dum_q <= ent_q.start_usec - pkt_q.time_usec;
        du_neg_q <= 1'b1;
      end
    end
    if (cmd_i.fin_mul) begin
      // x1000 = x1024 - x16 - x8
      ms_q <= (43'(ds_q) <<< 10) - (43'(ds_q) <<< 4) - (43'(ds_q) <<< 3);
      dq_q <= du_prod[40:30];
    end
  end

  // result: quotient truncates toward zero, sign restored here
  logic [41:0] dur;
  assign dur = ms_q[41:0] + (du_neg_q ? (42'd0 - {31'd0, dq_q}) : {31'd0, dq_q});

  always_comb begin
    res_d = '0;
    if (found_q) begin
      res_d.slot = 10'(cur_q);
      if (!ent_q.active) begin
        res_d.outcome = tct_pkg::OutMatchClosed;
      end else begin
        res_d.outcome = tct_pkg::OutMatchActive;
        res_d.direction = fdir_q;
      end
    end else if (have_free_q) begin
      res_d.slot = 10'(free_q);
      res_d.outcome = tct_pkg::OutCreated;
      res_d.direction = tct_pkg::DirFwd;
    end else begin
      res_d.outcome = tct_pkg::OutFull;
    end
    if (live && flg) begin
      res_d.closed = 1'b1;
      res_d.closed_out_count = ent_q.out_count;
      res_d.closed_in_count = ent_q.in_count;
      res_d.elapsed_ms = dur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) res_q <= '0;
    else if (cmd_i.commit) res_q <= res_d;
  end

  assign done_o = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/tcp_connection_tracker.sv
// TCP connection tracker over a hashed flow table (linear probe, FNV-1a).
// Input: drive pkt_i and raise start while busy is low; that beat is taken.
// Output: one result beat per packet, shown on result_o for one cycle with
// done_o high. The receiver cannot stall it.
// Sequence: a non-TCP packet goes from the hash state straight to its result.
// A TCP packet hashes its twelve tuple bytes, issues the read of the hash
// slot, then checks each slot from the hash slot up to the match or the
// table end, and finishes with the prep, multiply, commit and result steps.
// The probe walks the table memory one slot per read.
// Throughput: one packet at a time; busy stays high until its result.
// Reset: a clearing pass writes every table word (active bit included)
// to zero, with busy high.
module tcp_connection_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tct_pkg::pkt_t pkt_i,
  output logic          done_o,
  output tct_pkg::res_t result_o
);

  tct_pkg::cmd_t cmd;
  tct_pkg::sts_t sts;

  tct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tct_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pkt_i    (pkt_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

FILE: rtl/tct_checker.sv
module tct_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_i,
  input tct_pkg::res_t result_i
);

  // a taken beat makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised");

  // result strobe comes with busy already low
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy) else $error("done while busy");

  // slot zero when table is full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && result_i.outcome == tct_pkg::OutFull) |-> result_i.slot == '0)
    else $error("full with slot");

  // closed only for counted packets
  a_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && result_i.closed) |-> result_i.direction != tct_pkg::DirNone)
    else $error("closed without direction");

endmodule

bind tcp_connection_tracker tct_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_i   (done_o),
  .result_i (result_o)
);
